### rtl/ldap_search_response_parser_defines.svh
// assertion macros for the ldap search response parser
// used by the top level; expects clk and arst_n in scope
`ifndef LDAP_SEARCH_RESPONSE_PARSER_DEFINES_SVH
`define LDAP_SEARCH_RESPONSE_PARSER_DEFINES_SVH

// property must hold on every clock out of reset
`define LSRP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define LSRP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/lsrp_pkg.sv
// shared types and constants for the ldap search response parser
// no dependencies
package lsrp_pkg;

	// default longest long-form length field, in bytes
	localparam int MAX_LENGTH_BYTES_DEF = 4;

	// result queue depth; two free slots are needed to take a byte
	localparam int QUEUE_DEPTH = 4;

	// ber tags
	localparam logic [7:0] TAG_INTEGER      = 8'h02;
	localparam logic [7:0] TAG_OCTET_STRING = 8'h04;
	localparam logic [7:0] TAG_BIND_RSP     = 8'h61;
	localparam logic [7:0] TAG_SEARCH_ENTRY = 8'h64;
	localparam logic [7:0] TAG_SEARCH_DONE  = 8'h65;

	// long-form length markers
	localparam logic [7:0] LEN_LONG_MIN = 8'h81;
	localparam logic [7:0] LEN_LONG_MAX = 8'h89;
	localparam logic [7:0] LEN_LONG_BIT = 8'h80;

	// output characters
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_EQUALS  = 8'h3d;
	localparam logic [7:0] CH_AMP     = 8'h26;

	// parse position
	typedef enum logic [13:0] {
		PH_SKIPHDR   = 14'h0001,
		PH_DISPATCH  = 14'h0002,
		PH_ID        = 14'h0004,
		PH_AFTER_ID  = 14'h0008,
		PH_ENTRY_HDR = 14'h0010,
		PH_OBJNAME   = 14'h0020,
		PH_RES_HDR   = 14'h0040,
		PH_ENUM      = 14'h0080,
		PH_MATCHED   = 14'h0100,
		PH_DIAG      = 14'h0200,
		PH_NAME      = 14'h0400,
		PH_SET_HDR   = 14'h0800,
		PH_VALUE     = 14'h1000,
		PH_REST      = 14'h2000
	} phase_t;

	// position inside one tag/length header
	typedef enum logic [3:0] {
		HS_TAG  = 4'b0001,
		HS_LEN  = 4'b0010,
		HS_LONG = 4'b0100,
		HS_BODY = 4'b1000
	} hdr_step_t;

	// input transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_start;
	} raw_t;

	// output transaction
	typedef struct packed {
		logic [7:0] text_char;
		logic       char_valid;
		logic       last_of_run;
		logic       response_done;
		logic       server_error;
		logic [7:0] result_code;
	} text_t;

endpackage

### rtl/lsrp_chan_if.sv
// valid/ready channel carrying one payload struct
// payload type comes from lsrp_pkg at the instance
interface lsrp_chan_if #(
	parameter type T = logic [7:0]
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/ldap_search_response_parser.sv
// ldap search response parser: ber walker plus result queue
// depends on lsrp_pkg, lsrp_chan_if and ldap_search_response_parser_defines.svh
//
// channel | dir | payload
// raw     | in  | data_byte, chunk_start
// text    | out | text_char, char_valid, last_of_run, response_done, server_error, result_code
//
// one byte is parsed in the cycle it is accepted; it yields one or two transactions
// that enter a four-entry result queue, drained one per cycle while text is ready.
// a byte is taken whenever two queue slots are free, so single-transaction bytes
// stream at one per cycle under a ready sink; two-character bytes fill two queue slots.
// arst_n clears the parse state, the sticky flags and the queue; no clearing pass.
// a stalled text sink fills the queue and then holds off raw.
`include "ldap_search_response_parser_defines.svh"

module ldap_search_response_parser
	import lsrp_pkg::*;
#(
	parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lsrp_chan_if.sink   raw,
	lsrp_chan_if.source text
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// parser state
	phase_t      phase_q;
	hdr_step_t   hs_q;
	logic [3:0]  lbl_q;
	logic [31:0] acc_q;
	logic [31:0] cl_q;
	logic [31:0] sl_q;
	logic        done_q;
	logic        err_q;
	logic [7:0]  code_q;

	// next parser state and the transactions of this byte
	phase_t      phase_d;
	hdr_step_t   hs_d;
	logic [3:0]  lbl_d;
	logic [31:0] acc_d;
	logic [31:0] cl_d;
	logic [31:0] sl_d;
	logic        done_d;
	logic        err_d;
	logic [7:0]  code_d;
	logic        emit_b;
	logic        emit_end;
	logic [7:0]  end_ch;

	// result queue
	text_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic  in_acc;
	logic  out_acc;
	text_t item0;
	text_t item1;
	logic  two;

	assign raw.ready = (cnt_q <= CNT_W'(QUEUE_DEPTH - 2));
	assign in_acc    = raw.valid && raw.ready;
	assign out_acc   = text.valid && text.ready;

	// one byte through the ber walker
	always_comb begin : parse
		logic [7:0]  b;
		logic        hd_fire;
		logic [31:0] hd_len;
		logic        cd_fire;

		b       = raw.payload.data_byte;
		hd_fire = 1'b0;
		hd_len  = '0;
		cd_fire = 1'b0;

		phase_d  = raw.payload.chunk_start ? PH_SKIPHDR : phase_q;
		hs_d     = raw.payload.chunk_start ? HS_TAG : hs_q;
		lbl_d    = raw.payload.chunk_start ? 4'd0 : lbl_q;
		acc_d    = raw.payload.chunk_start ? 32'd0 : acc_q;
		cl_d     = raw.payload.chunk_start ? 32'd0 : cl_q;
		sl_d     = raw.payload.chunk_start ? 32'd0 : sl_q;
		done_d   = done_q;
		err_d    = err_q;
		code_d   = code_q;
		emit_b   = 1'b0;
		emit_end = 1'b0;
		end_ch   = 8'd0;

		// main step on the header position
		if (phase_d == PH_REST) begin
			if (sl_d != 32'd0) sl_d = sl_d - 32'd1;
			if (sl_d == 32'd0) phase_d = PH_SKIPHDR;
		end else begin
			unique case (hs_d)
				HS_TAG: begin
					if (phase_d == PH_DISPATCH) begin
						if (b == TAG_INTEGER) phase_d = PH_ID;
						else if (b == TAG_OCTET_STRING) phase_d = PH_NAME;
						else phase_d = PH_SKIPHDR;
					end else if (phase_d == PH_AFTER_ID) begin
						if (b == TAG_SEARCH_ENTRY) begin
							emit_end = 1'b1;
							end_ch   = CH_NEWLINE;
							phase_d  = PH_ENTRY_HDR;
						end else if (b == TAG_SEARCH_DONE || b == TAG_BIND_RSP) begin
							done_d  = 1'b1;
							phase_d = PH_RES_HDR;
						end else begin
							phase_d = PH_ID;
						end
					end else if (phase_d == PH_VALUE) begin
						if (sl_d != 32'd0) sl_d = sl_d - 32'd1;
					end
					hs_d = HS_LEN;
				end
				HS_LEN: begin
					if (phase_d == PH_VALUE && sl_d != 32'd0) sl_d = sl_d - 32'd1;
					if (b >= LEN_LONG_MIN && b <= LEN_LONG_MAX) begin
						lbl_d = b[3:0];
						acc_d = (b[3:0] > 4'(MAX_LENGTH_BYTES)) ? 32'hffff_ffff : 32'd0;
						hs_d  = HS_LONG;
					end else begin
						hd_fire = 1'b1;
						hd_len  = {24'd0, b};
					end
				end
				HS_LONG: begin
					if (phase_d == PH_VALUE && sl_d != 32'd0) sl_d = sl_d - 32'd1;
					if (|acc_d[31:24]) acc_d = 32'hffff_ffff;
					else acc_d = {acc_d[23:0], b};
					if (lbl_d != 4'd0) lbl_d = lbl_d - 4'd1;
					if (lbl_d == 4'd0) begin
						hd_fire = 1'b1;
						hd_len  = acc_d;
					end
				end
				HS_BODY: begin
					if (phase_d == PH_NAME) begin
						emit_b = 1'b1;
					end else if (phase_d == PH_VALUE) begin
						emit_b = 1'b1;
						if (sl_d != 32'd0) sl_d = sl_d - 32'd1;
					end else if (phase_d == PH_ENUM) begin
						code_d = b;
						if (b != 8'd0) err_d = 1'b1;
					end
					if (cl_d != 32'd0) cl_d = cl_d - 32'd1;
					if (cl_d == 32'd0) cd_fire = 1'b1;
				end
				default: begin
					hs_d = HS_TAG;
				end
			endcase
		end

		// header complete: decide on the content
		if (hd_fire) begin
			hs_d = HS_TAG;
			unique case (phase_d)
				PH_ENTRY_HDR: phase_d = PH_OBJNAME;
				PH_RES_HDR:   phase_d = PH_ENUM;
				PH_SET_HDR: begin
					sl_d = hd_len;
					if (hd_len == 32'd0) begin
						emit_end = 1'b1;
						end_ch   = CH_AMP;
						phase_d  = PH_SKIPHDR;
					end else begin
						phase_d = PH_VALUE;
					end
				end
				PH_ID, PH_OBJNAME, PH_ENUM, PH_MATCHED, PH_DIAG, PH_NAME, PH_VALUE: begin
					if (hd_len == 32'd0) begin
						cd_fire = 1'b1;
					end else begin
						cl_d = hd_len;
						hs_d = HS_BODY;
					end
				end
				default: phase_d = PH_DISPATCH;
			endcase
		end

		// content complete: move to the next element
		if (cd_fire) begin
			hs_d = HS_TAG;
			unique case (phase_d)
				PH_ID:      phase_d = PH_AFTER_ID;
				PH_ENUM:    phase_d = PH_MATCHED;
				PH_MATCHED: phase_d = PH_DIAG;
				PH_NAME: begin
					emit_end = 1'b1;
					end_ch   = CH_EQUALS;
					phase_d  = PH_SET_HDR;
				end
				PH_VALUE: begin
					emit_end = 1'b1;
					end_ch   = CH_AMP;
					phase_d  = (sl_d != 32'd0) ? PH_REST : PH_SKIPHDR;
				end
				default: phase_d = PH_SKIPHDR;
			endcase
		end
	end

	// transactions written to the queue for this byte
	always_comb begin
		two   = emit_b && emit_end;
		item0 = '{
			text_char:     emit_b ? raw.payload.data_byte : (emit_end ? end_ch : 8'd0),
			char_valid:    emit_b || emit_end,
			last_of_run:   !two,
			response_done: done_d,
			server_error:  err_d,
			result_code:   code_d
		};
		item1 = '{
			text_char:     end_ch,
			char_valid:    1'b1,
			last_of_run:   1'b1,
			response_done: done_d,
			server_error:  err_d,
			result_code:   code_d
		};
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIPHDR;
			hs_q    <= HS_TAG;
			lbl_q   <= '0;
			acc_q   <= '0;
			cl_q    <= '0;
			sl_q    <= '0;
			done_q  <= 1'b0;
			err_q   <= 1'b0;
			code_q  <= '0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			hs_q    <= hs_d;
			lbl_q   <= lbl_d;
			acc_q   <= acc_d;
			cl_q    <= cl_d;
			sl_q    <= sl_d;
			done_q  <= done_d;
			err_q   <= err_d;
			code_q  <= code_d;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (in_acc) wr_ptr_q <= wr_ptr_q + (two ? PTR_W'(2) : PTR_W'(1));
			if (out_acc) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			cnt_q <= cnt_q
				+ (in_acc ? (two ? CNT_W'(2) : CNT_W'(1)) : CNT_W'(0))
				- (out_acc ? CNT_W'(1) : CNT_W'(0));
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mem_q[wr_ptr_q] <= item0;
			if (two) mem_q[wr_ptr_q + PTR_W'(1)] <= item1;
		end
	end

	assign text.valid   = (cnt_q != '0);
	assign text.payload = mem_q[rd_ptr_q];

	// checks
	`LSRP_NEVER(a_queue_overflow, cnt_q > CNT_W'(QUEUE_DEPTH), "result queue overfilled")
	`LSRP_ASSERT(a_accept_gives_output, in_acc |=> text.valid, "accepted byte left no transaction")
	`LSRP_ASSERT(a_first_of_pair_is_char, text.valid && !text.payload.last_of_run |-> text.payload.char_valid, "non-final transaction without a character")
	`LSRP_ASSERT(a_done_sticky, done_q |=> done_q, "response done flag dropped")

endmodule
